@@ hdl/sine_orthogonal_matrix_generator_unit_macros.svh @@
// Assertion macros for the sine orthogonal matrix generator.
// Used by the top level only; no other dependencies.
`ifndef SINE_ORTHOGONAL_MATRIX_GENERATOR_UNIT_MACROS_SVH
`define SINE_ORTHOGONAL_MATRIX_GENERATOR_UNIT_MACROS_SVH
// property that must hold at every rising clock edge outside reset
`define SOMG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define SOMG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ hdl/somg_pkg.sv @@
// Shared types and constants for the sine orthogonal matrix generator.
// No dependencies.
package somg_pkg;
    localparam int unsigned CfgCount = 8;
    localparam logic [2:0] CFG_ROW_COUNT = 3'd0;
    localparam logic [2:0] CFG_COL_COUNT = 3'd1;
    localparam logic [2:0] CFG_ROW_BLOCK = 3'd2;
    localparam logic [2:0] CFG_COL_BLOCK = 3'd3;
    localparam logic [2:0] CFG_GRID_SHAPE = 3'd4;
    localparam logic [2:0] CFG_GRID_POS = 3'd5;
    localparam logic [2:0] CFG_SCALE = 3'd6;
    localparam logic [2:0] CFG_ANGLE_STEP = 3'd7;
    localparam logic signed [33:0] GainQ30 = 34'sd652032874;

    // commands from controller to datapath
    typedef struct packed {
        logic start;   // restart the walk (reset, config or restart word)
        logic launch;  // begin evaluating the current element
        logic advance; // step the walk past the current element
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic done;      // walk finished or empty
        logic busy;      // element evaluation in progress
        logic ready;     // element value available
    } t_status;

    // arctangent table in turns times 2^32
    function automatic logic [31:0] atan_turn(input logic [4:0] s);
        case (s)
            5'd0: atan_turn = 32'h20000000; 5'd1: atan_turn = 32'h12E4051E;
            5'd2: atan_turn = 32'h09FB385B; 5'd3: atan_turn = 32'h051111D4;
            5'd4: atan_turn = 32'h028B0D43; 5'd5: atan_turn = 32'h0145D7E1;
            5'd6: atan_turn = 32'h00A2F61E; 5'd7: atan_turn = 32'h00517C55;
            5'd8: atan_turn = 32'h0028BE53; 5'd9: atan_turn = 32'h00145F2F;
            5'd10: atan_turn = 32'h000A2F98; 5'd11: atan_turn = 32'h000517CC;
            5'd12: atan_turn = 32'h00028BE6; 5'd13: atan_turn = 32'h000145F3;
            5'd14: atan_turn = 32'h0000A2FA; 5'd15: atan_turn = 32'h0000517D;
            5'd16: atan_turn = 32'h000028BE; 5'd17: atan_turn = 32'h0000145F;
            5'd18: atan_turn = 32'h00000A30; 5'd19: atan_turn = 32'h00000518;
            5'd20: atan_turn = 32'h0000028C; 5'd21: atan_turn = 32'h00000146;
            5'd22: atan_turn = 32'h000000A3; 5'd23: atan_turn = 32'h00000051;
            5'd24: atan_turn = 32'h00000029; 5'd25: atan_turn = 32'h00000014;
            5'd26: atan_turn = 32'h0000000A; 5'd27: atan_turn = 32'h00000005;
            5'd28: atan_turn = 32'h00000003; 5'd29: atan_turn = 32'h00000001;
            5'd30: atan_turn = 32'h00000001;
            default: atan_turn = 32'h00000000;
        endcase
    endfunction
endpackage

@@ hdl/somg_ctrl.sv @@
// Controller for the sine orthogonal matrix generator: sequences one word.
// Depends on somg_pkg.
module somg_ctrl import somg_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_restart,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output logic    o_out_has,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic r_start, n_start;
    logic r_has, n_has;
    logic accept;

    assign o_in_ready  = (r_state == ST_IDLE) && !r_start;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_has   = r_has;

    // pending restart: applied in idle before the next word is judged
    always_comb begin
        n_state = r_state;
        n_start = r_start;
        n_has = r_has;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (r_start) begin
                    o_cmd.start = 1'b1;
                    n_start = 1'b0;
                end else if (accept && i_restart) begin
                    o_cmd.start = 1'b1;
                    n_state = ST_CALC;
                end else if (accept) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (i_status.done) begin
                    n_has = 1'b0;
                    n_state = ST_OUT;
                end else begin
                    n_has = 1'b1;
                    o_cmd.launch = 1'b1;
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_status.ready) begin
                    o_cmd.advance = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (i_cfg_we) n_start = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_start <= 1'b1;
            r_has <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= n_start;
            r_has <= n_has;
        end
    end
endmodule

@@ hdl/somg_datapath.sv @@
// Datapath: configuration store, block-cyclic walk, phase, CORDIC, scaling.
// Depends on somg_pkg.
module somg_datapath import somg_pkg::*; #(
    parameter int INDEX_BITS  = 16,
    parameter int SINE_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic [15:0] o_grow,
    output logic [15:0] o_gcol,
    output logic [15:0] o_lrow,
    output logic [15:0] o_lcol,
    output logic signed [31:0] o_value,
    output logic        o_last
);
    localparam int IB = INDEX_BITS;
    localparam int SB = $clog2(SINE_STAGES + 1);

    // configuration registers
    logic [IB-1:0] r_m, r_n, r_mb, r_nb;
    logic [15:0] r_shape, r_pos;
    logic [31:0] r_scale;
    logic [30:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m <= IB'(1); r_n <= IB'(1); r_mb <= IB'(1); r_nb <= IB'(1);
            r_shape <= 16'd257; r_pos <= 16'd0;
            r_scale <= 32'h80000000; r_step <= 31'h40000000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:  r_m <= IB'(i_cfg_data[15:0]);
                CFG_COL_COUNT:  r_n <= IB'(i_cfg_data[15:0]);
                CFG_ROW_BLOCK:  r_mb <= IB'(i_cfg_data[15:0]);
                CFG_COL_BLOCK:  r_nb <= IB'(i_cfg_data[15:0]);
                CFG_GRID_SHAPE: r_shape <= i_cfg_data[15:0];
                CFG_GRID_POS:   r_pos <= i_cfg_data[15:0];
                CFG_SCALE:      r_scale <= i_cfg_data;
                CFG_ANGLE_STEP: r_step <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // derived layout values, widened so sums never wrap
    logic [IB:0] mb, nb;
    logic [8:0] np, nq;
    logic [IB+8:0] frow, fcol, row_jump, col_jump;
    assign mb = (r_mb == '0) ? (IB+1)'(1) : {1'b0, r_mb};
    assign nb = (r_nb == '0) ? (IB+1)'(1) : {1'b0, r_nb};
    assign np = (r_shape[7:0] == 8'd0) ? 9'd1 : {1'b0, r_shape[7:0]};
    assign nq = (r_shape[15:8] == 8'd0) ? 9'd1 : {1'b0, r_shape[15:8]};
    assign frow = (IB+9)'(r_pos[7:0]) * (IB+9)'(mb) + (IB+9)'(1);
    assign fcol = (IB+9)'(r_pos[15:8]) * (IB+9)'(nb) + (IB+9)'(1);
    assign row_jump = (IB+9)'(mb) * (IB+9)'(np - 9'd1);
    assign col_jump = (IB+9)'(nb) * (IB+9)'(nq - 9'd1);

    // walk state
    logic [IB-1:0] r_grow, r_gcol, r_lrow, r_lcol, r_rib, r_cib;
    logic r_done;
    logic empty;
    logic [IB+9:0] nr, nc;
    logic row_end, col_end;
    assign empty = !(r_pos[7:0] < np[7:0] || np == 9'd256) ? 1'b1 :
                   !({1'b0, r_pos[15:8]} < nq) ? 1'b1 :
                   (frow > (IB+9)'(r_m)) || (fcol > (IB+9)'(r_n));
    assign row_end = ({1'b0, r_rib} + (IB+1)'(1)) >= mb;
    assign col_end = ({1'b0, r_cib} + (IB+1)'(1)) >= nb;
    assign nr = (IB+10)'(r_grow) + (IB+10)'(1) + (row_end ? {1'b0, row_jump} : '0);
    assign nc = (IB+10)'(r_gcol) + (IB+10)'(1) + (col_end ? {1'b0, col_jump} : '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_lrow <= '0; r_lcol <= '0; r_rib <= '0; r_cib <= '0;
            r_done <= empty;
            r_grow <= empty ? '0 : IB'(frow);
            r_gcol <= empty ? '0 : IB'(fcol);
        end else if (i_cmd.advance) begin
            if (nr <= (IB+10)'(r_m)) begin
                r_grow <= IB'(nr);
                r_lrow <= r_lrow + IB'(1);
                r_rib <= row_end ? '0 : r_rib + IB'(1);
            end else if (nc <= (IB+10)'(r_n)) begin
                r_gcol <= IB'(nc);
                r_lcol <= r_lcol + IB'(1);
                r_cib <= col_end ? '0 : r_cib + IB'(1);
                r_grow <= IB'(frow);
                r_lrow <= '0;
                r_rib <= '0;
            end else begin
                r_done <= 1'b1;
            end
        end
    end

    // evaluation sequencer: product, modulo by subtraction, angle, quadrant split, CORDIC, scale, round
    localparam logic [2:0] PH_MUL = 3'd0, PH_MOD = 3'd1, PH_ANG = 3'd2,
                           PH_ROT = 3'd3, PH_SCL = 3'd4, PH_RND = 3'd5, PH_IDLE = 3'd6,
                           PH_QUAD = 3'd7;
    logic [2:0] r_ph;
    logic [2*IB-1:0] r_prod;
    logic [2*IB-1:0] r_modsh;
    logic [$clog2(IB+2)-1:0] r_bit;
    logic [IB+1:0] modulus;
    logic [31:0] r_angle;
    logic [1:0] r_quad;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic [SB-1:0] r_s;
    logic signed [66:0] r_mul;
    logic signed [31:0] r_val;
    logic [31:0] quad_ang;
    logic signed [33:0] xs, ys;
    logic signed [31:0] at;
    logic signed [33:0] sine;
    logic signed [66:0] rnd;

    assign modulus = (IB+2)'({1'b0, r_m} + (IB+1)'(1)) << 1;
    assign quad_ang = r_angle - {(r_angle[31:30] + {1'b0, r_angle[29]}), 30'd0};
    assign xs = r_x >>> r_s;
    assign ys = r_y >>> r_s;
    assign at = $signed(atan_turn(5'(r_s)));
    always_comb begin
        case (r_quad)
            2'd0: sine = r_y;
            2'd1: sine = r_x;
            2'd2: sine = -r_y;
            default: sine = -r_x;
        endcase
    end
    assign rnd = (r_mul + 67'sd1073741824) >>> 31;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_IDLE;
        end else begin
            case (r_ph)
                PH_IDLE: if (i_cmd.launch) r_ph <= PH_MUL;
                PH_MUL: begin
                    r_prod <= r_grow * r_gcol;
                    r_bit <= ($clog2(IB+2))'(IB);
                    r_ph <= PH_MOD;
                end
                PH_MOD: begin
                    // restoring reduction, one shifted modulus per cycle
                    if ({1'b0, r_prod} >= ((2*IB+1)'(modulus) << r_bit))
                        r_prod <= (2*IB)'({1'b0, r_prod} - ((2*IB+1)'(modulus) << r_bit));
                    if (r_bit == '0) r_ph <= PH_ANG;
                    else r_bit <= r_bit - 1'b1;
                end
                PH_ANG: begin
                    r_angle <= 32'(r_prod * r_step);
                    r_ph <= PH_QUAD;
                end
                PH_QUAD: begin
                    // split into nearest quarter turn and remainder
                    r_quad <= 2'(({1'b0, r_angle} + 33'h20000000) >> 30);
                    r_z <= $signed({quad_ang[31], quad_ang});
                    r_s <= '0;
                    r_x <= GainQ30;
                    r_y <= '0;
                    r_ph <= PH_ROT;
                end
                PH_ROT: begin
                    if (r_s == SB'(SINE_STAGES)) begin
                        r_ph <= PH_SCL;
                    end else begin
                        if (!r_z[32]) begin
                            r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - at;
                        end else begin
                            r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + at;
                        end
                        r_s <= r_s + 1'b1;
                    end
                end
                PH_SCL: begin
                    r_mul <= sine * $signed({35'd0, r_scale});
                    r_ph <= PH_RND;
                end
                PH_RND: begin
                    if (rnd > 67'sd1073741824) r_val <= 32'sd1073741824;
                    else if (rnd < -67'sd1073741824) r_val <= -32'sd1073741824;
                    else r_val <= 32'(rnd);
                    r_ph <= PH_IDLE;
                end
                default: r_ph <= PH_IDLE;
            endcase
        end
    end
    assign o_status.ready = (r_ph == PH_IDLE);
    assign o_status.busy = (r_ph != PH_IDLE);
    assign o_status.done = r_done;

    // result registers, captured as the walk advances
    logic [15:0] r_og, r_oc, r_olr, r_olc;
    logic signed [31:0] r_ov;
    always_ff @(posedge i_clk) begin
        if (i_cmd.advance) begin
            r_og <= 16'(r_grow); r_oc <= 16'(r_gcol);
            r_olr <= 16'(r_lrow); r_olc <= 16'(r_lcol);
            r_ov <= r_val;
        end
    end
    assign o_grow = r_og; assign o_gcol = r_oc;
    assign o_lrow = r_olr; assign o_lcol = r_olc;
    assign o_value = r_ov;
    assign o_last = r_done;
endmodule

@@ hdl/sine_orthogonal_matrix_generator_unit.sv @@
// The phase reduction is bit-serial and the CORDIC iterative, both in one datapath.
// Only one word is in flight: input is ready again only after the result is taken.
// A finished or empty walk answers without evaluating an element. Reset is
// synchronous, active low, restores register defaults and restarts the walk.
`include "sine_orthogonal_matrix_generator_unit_macros.svh"
module sine_orthogonal_matrix_generator_unit import somg_pkg::*; #(
    parameter int INDEX_BITS  = 16,
    parameter int SINE_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_has_element,
    output logic [15:0] o_global_row,
    output logic [15:0] o_global_col,
    output logic [15:0] o_local_row,
    output logic [15:0] o_local_col,
    output logic signed [31:0] o_element_value,
    output logic        o_last
);
    t_cmd cmd;
    t_status status;
    logic has;
    logic [15:0] g_r, g_c, l_r, l_c;
    logic signed [31:0] val;
    logic lst;

    somg_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we, .i_in_valid, .o_in_ready, .i_restart,
        .o_out_valid, .i_out_ready, .o_out_has(has), .o_cmd(cmd), .i_status(status)
    );
    somg_datapath #(.INDEX_BITS(INDEX_BITS), .SINE_STAGES(SINE_STAGES)) u_dp (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_cmd(cmd), .o_status(status), .o_grow(g_r), .o_gcol(g_c),
        .o_lrow(l_r), .o_lcol(l_c), .o_value(val), .o_last(lst)
    );

    // zero every field when no element is produced
    assign o_has_element = has;
    assign o_global_row = has ? g_r : 16'd0;
    assign o_global_col = has ? g_c : 16'd0;
    assign o_local_row = has ? l_r : 16'd0;
    assign o_local_col = has ? l_c : 16'd0;
    assign o_element_value = has ? val : 32'sd0;
    assign o_last = has ? lst : 1'b0;

    `SOMG_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "ready while result pending")
    `SOMG_ASSERT(a_value_range, i_clk, i_rst_n, (o_element_value <= 32'sd1073741824) && (o_element_value >= -32'sd1073741824), "value out of range")
    `SOMG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_element_value), "result dropped")
endmodule

@@ tb/tb.sv @@
// Self-checking bench for the sine orthogonal matrix generator unit.
// Depends on somg_pkg and the generator RTL; predicts each word in-line.
`timescale 1ns / 1ps
module tb;
    import somg_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_restart;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_has_element;
    logic [15:0] o_global_row;
    logic [15:0] o_global_col;
    logic [15:0] o_local_row;
    logic [15:0] o_local_col;
    logic signed [31:0] o_element_value;
    logic        o_last;

    typedef struct packed {
        logic        has;
        logic [15:0] grow;
        logic [15:0] gcol;
        logic [15:0] lrow;
        logic [15:0] lcol;
        logic [31:0] val;
        logic        last;
    } t_element;

    sine_orthogonal_matrix_generator_unit u_dut (.*);

    // generator registers and walk state as predicted
    logic [15:0] m_rows, m_cols, m_rblk, m_cblk, m_shape, m_pos;
    logic [31:0] m_scale;
    logic [30:0] m_step;
    longint unsigned w_grow, w_gcol, w_lrow, w_lcol, w_rib, w_cib;
    bit w_done;

    t_element    pending_q[$];
    int          err_count;
    int          words_sent;
    int          elems_seen;
    int          lasts_seen;
    longint      cycle_count;
    bit          stall_on;

    function automatic longint unsigned one_min(longint unsigned v);
        return v == 0 ? 1 : v;
    endfunction

    function automatic longint unsigned first_owned_row();
        return longint'(m_pos[7:0]) * one_min(m_rblk) + 1;
    endfunction

    function automatic longint unsigned first_owned_col();
        return longint'(m_pos[15:8]) * one_min(m_cblk) + 1;
    endfunction

    function automatic void restart_walk();
        w_lrow = 0; w_lcol = 0; w_rib = 0; w_cib = 0;
        w_done = !(m_pos[7:0] < one_min(m_shape[7:0]) &&
                   m_pos[15:8] < one_min(m_shape[15:8]) &&
                   first_owned_row() <= m_rows && first_owned_col() <= m_cols);
        w_grow = w_done ? 0 : first_owned_row();
        w_gcol = w_done ? 0 : first_owned_col();
    endfunction

    // rotation-mode sine of a turn fraction, Q2.30
    function automatic longint sine_of_turn(logic [31:0] a);
        logic [31:0] quad, r;
        longint z, x, y, nx;
        quad = ((a + 32'h2000_0000) >> 30) & 32'd3;
        r = a - (quad << 30);
        z = longint'($signed(r));
        x = 652032874; y = 0;
        for (int s = 0; s < 24; s++) begin
            if (z >= 0) begin
                nx = x - (y >>> s); y = y + (x >>> s); z -= longint'(atan_turn(s[4:0]));
            end else begin
                nx = x + (y >>> s); y = y - (x >>> s); z += longint'(atan_turn(s[4:0]));
            end
            x = nx;
        end
        case (quad[1:0])
            2'd0: return y;
            2'd1: return x;
            2'd2: return -y;
            default: return -x;
        endcase
    endfunction

    function automatic void step_walk();
        longint unsigned mb, nb, np, nq, nr, nc;
        bit rend, cend;
        mb = one_min(m_rblk); nb = one_min(m_cblk);
        np = one_min(m_shape[7:0]); nq = one_min(m_shape[15:8]);
        rend = w_rib + 1 >= mb;
        nr = w_grow + 1 + (rend ? mb * (np - 1) : 0);
        if (nr <= m_rows) begin
            w_grow = nr; w_lrow++; w_rib = rend ? 0 : w_rib + 1;
            return;
        end
        cend = w_cib + 1 >= nb;
        nc = w_gcol + 1 + (cend ? nb * (nq - 1) : 0);
        if (nc <= m_cols) begin
            w_gcol = nc; w_lcol++; w_cib = cend ? 0 : w_cib + 1;
            w_grow = first_owned_row(); w_lrow = 0; w_rib = 0;
            return;
        end
        w_done = 1;
    endfunction

    function automatic t_element next_element(bit rs);
        t_element e;
        longint unsigned k, prod64;
        logic [31:0] ang;
        longint v;
        if (rs) restart_walk();
        e = '0;
        if (w_done) return e;
        k = (w_grow * w_gcol) % (2 * (longint'(m_rows) + 1));
        prod64 = k * longint'(m_step);
        ang = prod64[31:0];
        v = sine_of_turn(ang) * longint'(m_scale);
        v = (v + 64'sd1073741824) >>> 31;
        if (v > 1073741824) v = 1073741824;
        if (v < -1073741824) v = -1073741824;
        e.has = 1; e.grow = w_grow[15:0]; e.gcol = w_gcol[15:0];
        e.lrow = w_lrow[15:0]; e.lcol = w_lcol[15:0]; e.val = v[31:0];
        step_walk();
        e.last = w_done;
        return e;
    endfunction

    // clock and cycle guard
    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3_000_000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stall pattern: quiet or busy stretches, each chosen at random
    always @(posedge i_clk) begin
        if (cycle_count % 500 == 0) stall_on <= $urandom_range(0, 1);
        i_out_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // check each word taken from the output
    always @(posedge i_clk) begin
        t_element e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                $error("unexpected result word");
                err_count++;
            end else begin
                e = pending_q.pop_front();
                if (o_has_element) elems_seen++;
                if (o_last) lasts_seen++;
                if (o_has_element !== e.has) begin
                    $error("has_element exp %0d got %0d", e.has, o_has_element); err_count++;
                end
                if (o_global_row !== e.grow) begin
                    $error("global_row exp %0d got %0d", e.grow, o_global_row); err_count++;
                end
                if (o_global_col !== e.gcol) begin
                    $error("global_col exp %0d got %0d", e.gcol, o_global_col); err_count++;
                end
                if (o_local_row !== e.lrow) begin
                    $error("local_row exp %0d got %0d", e.lrow, o_local_row); err_count++;
                end
                if (o_local_col !== e.lcol) begin
                    $error("local_col exp %0d got %0d", e.lcol, o_local_col); err_count++;
                end
                if (o_element_value !== e.val) begin
                    $error("element_value exp %0d got %0d", $signed(e.val), o_element_value);
                    err_count++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); err_count++;
                end
            end
        end
    end

    // send one word; predict at acceptance
    task automatic send_word(bit rs);
        @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_restart  <= rs;
        do @(posedge i_clk); while (!o_in_ready);
        pending_q.push_back(next_element(rs));
        words_sent++;
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // write one register while idle
    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        i_cfg_we <= 1'b1; i_cfg_index <= idx; i_cfg_data <= d;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROW_COUNT:  m_rows  = d[15:0];
            CFG_COL_COUNT:  m_cols  = d[15:0];
            CFG_ROW_BLOCK:  m_rblk  = d[15:0];
            CFG_COL_BLOCK:  m_cblk  = d[15:0];
            CFG_GRID_SHAPE: m_shape = d[15:0];
            CFG_GRID_POS:   m_pos   = d[15:0];
            CFG_SCALE:      m_scale = d;
            default:        m_step  = d[30:0];
        endcase
        restart_walk();
        @(posedge i_clk);
    endtask

    task automatic set_layout(logic [15:0] mr, logic [15:0] nc, logic [15:0] mb,
                              logic [15:0] nb, logic [15:0] sh, logic [15:0] ps);
        longint unsigned st;
        drain();
        st = (longint'(1) << 32) / (2 * (longint'(mr) + 1));
        write_reg(CFG_ROW_COUNT, {16'h0, mr});
        write_reg(CFG_COL_COUNT, {16'h0, nc});
        write_reg(CFG_ROW_BLOCK, {16'h0, mb});
        write_reg(CFG_COL_BLOCK, {16'h0, nb});
        write_reg(CFG_GRID_SHAPE, {16'h0, sh});
        write_reg(CFG_GRID_POS, {16'h0, ps});
        write_reg(CFG_ANGLE_STEP, st[31:0]);
    endtask

    // send n words with bursty gaps; restarts now and then
    task automatic walk_words(int n, int restart_pct);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++) begin
            if (burst == 0) begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
            burst--;
            send_word($urandom_range(0, 99) < restart_pct);
        end
    endtask

    // walks over default and tiny layouts, some in full, edge cases included
    task automatic test_directed();
        send_word(1'b0); send_word(1'b0); send_word(1'b1);
        set_layout(16'd3, 16'd2, 16'd1, 16'd1, 16'h0101, 16'h0000);
        for (int i = 0; i < 8; i++) send_word(1'b0);
        set_layout(16'd4, 16'd3, 16'd0, 16'd0, 16'h0000, 16'h0000);
        send_word(1'b1); send_word(1'b0);
        set_layout(16'd0, 16'd3, 16'd1, 16'd1, 16'h0101, 16'h0000);
        send_word(1'b0);
        set_layout(16'd4, 16'd4, 16'd1, 16'd1, 16'h0202, 16'h0505);
        send_word(1'b0);
        set_layout(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFEFE);
        send_word(1'b1);
        set_layout(16'd5, 16'd5, 16'd1, 16'd1, 16'h0101, 16'h0000);
        write_reg(CFG_SCALE, 32'h0000_0000);
        send_word(1'b0);
        drain();
        write_reg(CFG_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_ANGLE_STEP, 32'h7FFF_FFFF);
        send_word(1'b0); send_word(1'b0);
        drain();
        write_reg(CFG_SCALE, 32'h8000_0000);
    endtask

    // random block-cyclic layouts, 45 words sent per layout
    task automatic test_random_layouts();
        logic [15:0] mr, nc, sh, ps;
        for (int ph = 0; ph < 24; ph++) begin
            mr = $urandom_range(1, 40);
            nc = $urandom_range(1, 40);
            sh = {8'($urandom_range(0, 4)), 8'($urandom_range(0, 4))};
            ps = {8'($urandom_range(0, 4)), 8'($urandom_range(0, 4))};
            if (ph % 6 == 5) begin
                mr = 16'($urandom); nc = 16'($urandom);
            end
            set_layout(mr, nc, 16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)), sh, ps);
            write_reg(CFG_SCALE, $urandom_range(0, 3) == 0 ? $urandom : 32'h8000_0000);
            if (ph % 4 == 3) write_reg(CFG_ANGLE_STEP, {1'b0, 31'($urandom)});
            walk_words(45, 5);
            if (ph == 12) drain();
        end
    endtask

    initial begin
        err_count = 0; words_sent = 0; elems_seen = 0; lasts_seen = 0;
        cycle_count = 0; stall_on = 0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = CFG_ROW_COUNT; i_cfg_data = 0;
        i_in_valid = 0; i_restart = 0; i_out_ready = 0;
        m_rows = 1; m_cols = 1; m_rblk = 1; m_cblk = 1; m_shape = 16'h0101; m_pos = 0;
        m_scale = 32'h8000_0000; m_step = 31'h4000_0000;
        restart_walk();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_directed();
        test_random_layouts();
        drain();
        $display("Sent %0d words; %0d elements and %0d walk ends checked.",
                 words_sent, elems_seen, lasts_seen);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hdl
hdl/somg_pkg.sv
hdl/somg_ctrl.sv
hdl/somg_datapath.sv
hdl/sine_orthogonal_matrix_generator_unit.sv
tb/tb.sv
